/* rtl/hbd_pkg.sv */
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared types and constants of the Huffman byte decoder: command codes,
// queue entry layout and back-end state encoding.
// ----------------------------------------------------------------------------
package hbd_pkg;

    localparam int unsigned HBD_ALPHABET_SIZE = 256;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_DEC    = 2'd1;
    localparam logic [1:0] CMD_BUILD  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // node ids at or above this value are internal nodes
    localparam logic [8:0] NODE_BASE = 9'd256;

    typedef enum logic [1:0] {
        K_LOAD,
        K_DEC,
        K_BUILD
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  idx;
        logic [30:0] value;
        logic [7:0]  data;
        logic        last_byte;
        logic [3:0]  nbits;
    } t_qent;

    typedef enum logic [2:0] {
        B_IDLE,
        B_INIT,
        B_SCAN,
        B_MERGE0,
        B_MERGE1,
        B_DFETCH,
        B_DBIT,
        B_DEND
    } t_bstate;

endpackage

/* rtl/huffman_byte_decoder_unit.sv */
// ----------------------------------------------------------------------------
// huffman_byte_decoder_unit
// Static Huffman decoder over a byte alphabet: loads symbol weights, builds
// the code tree and decodes compressed bytes into symbols.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  input   | in        | i_in_valid / o_in_stall    | cmd, freq_index, freq_value,
//          |           |                            | data_byte, final_byte, pad_bits
//  output  | out       | o_out_valid / i_out_stall  | symbol, run_last
//
// Load writes one weight. Decode walks one tree node per code bit through
// the child memory's single read port and can be held by stalls on the
// output. Build repeats min scans over the forest memory (one slot per
// cycle on its port) and writes that memory twice per merge.
// Reset (synchronous, active low) marks all weights unloaded, so they read as zero, and drops the tree.
// A two-entry queue decouples input acceptance from execution; the output
// register holds a stalled symbol while the walk waits.
module huffman_byte_decoder_unit #(
    parameter int unsigned ALPHABET_SIZE = hbd_pkg::HBD_ALPHABET_SIZE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_freq_index,
    input  logic [30:0] i_freq_value,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    input  logic [3:0]  i_pad_bits,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_symbol,
    output logic        o_run_last
);
    import hbd_pkg::*;

    t_qent q_ent;
    logic  q_vld;
    logic  q_pop;

    // front: accept, classify, queue
    hbd_front #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_freq_index (i_freq_index),
        .i_freq_value (i_freq_value),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_pad_bits   (i_pad_bits),
        .o_q          (q_ent),
        .o_q_vld      (q_vld),
        .i_q_pop      (q_pop)
    );

    // back: build and decode
    hbd_back #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q_ent),
        .i_q_vld     (q_vld),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_symbol    (o_symbol),
        .o_run_last  (o_run_last)
    );

endmodule

/* rtl/hbd_front.sv */
// ----------------------------------------------------------------------------
// hbd_front
// Accepts input items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module hbd_front #(
    parameter int unsigned ALPHABET_SIZE = hbd_pkg::HBD_ALPHABET_SIZE
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_cmd,
    input  logic [7:0]    i_freq_index,
    input  logic [30:0]   i_freq_value,
    input  logic [7:0]    i_data_byte,
    input  logic          i_final_byte,
    input  logic [3:0]    i_pad_bits,
    output hbd_pkg::t_qent o_q,
    output logic          o_q_vld,
    input  logic          i_q_pop
);
    import hbd_pkg::*;

    t_qent      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       keep;
    logic       push;
    t_qent      ent;
    logic [3:0] pad_c;

    always_comb begin
        pad_c         = (i_pad_bits > 4'd8) ? 4'd8 : i_pad_bits;
        ent.kind      = K_LOAD;
        ent.idx       = i_freq_index;
        ent.value     = i_freq_value;
        ent.data      = i_data_byte;
        ent.last_byte = i_final_byte;
        ent.nbits     = i_final_byte ? (4'd8 - pad_c) : 4'd8;
        keep          = 1'b0;
        case (i_cmd)
            CMD_LOAD: begin
                ent.kind = K_LOAD;
                keep     = (9'(i_freq_index) < 9'(ALPHABET_SIZE));
            end
            CMD_DEC: begin
                ent.kind = K_DEC;
                keep     = 1'b1;
            end
            CMD_BUILD: begin
                ent.kind = K_BUILD;
                keep     = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall && keep;
    assign o_q        = r_mem[r_rp];
    assign o_q_vld    = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_q_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= ent;
        end
    end

endmodule

/* rtl/hbd_back.sv */
// ----------------------------------------------------------------------------
// hbd_back
// Executes queued commands: weight loads, tree build by repeated min scans,
// and bit-by-bit tree walk for decoding with an output register.
// ----------------------------------------------------------------------------
module hbd_back #(
    parameter int unsigned ALPHABET_SIZE = hbd_pkg::HBD_ALPHABET_SIZE
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hbd_pkg::t_qent i_q,
    input  logic           i_q_vld,
    output logic           o_q_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_symbol,
    output logic           o_run_last
);
    import hbd_pkg::*;

    localparam int unsigned AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam logic [AW-1:0] LAST_IDX  = AW'(ALPHABET_SIZE - 1);
    localparam logic [AW-1:0] LAST_NODE = AW'(ALPHABET_SIZE - 2);

    // memories
    logic [30:0] sw_mem [ALPHABET_SIZE];
    logic [41:0] fr_mem [ALPHABET_SIZE];   // {occupied, node, weight}
    logic [17:0] ch_mem [ALPHABET_SIZE];   // {child one, child zero}

    t_bstate r_state, n_state;
    logic [ALPHABET_SIZE-1:0] r_sw_vld, n_sw_vld;
    logic [AW-1:0] r_cnt, n_cnt, r_rd_idx, n_rd_idx, r_k, n_k;
    logic r_rd_vld, n_rd_vld, r_iss_done, n_iss_done;
    logic r_f1, n_f1, r_f2, n_f2;
    logic [31:0] r_m1, n_m1, r_m2, n_m2;
    logic [AW-1:0] r_i1, n_i1, r_i2, n_i2;
    logic [8:0] r_n1, n_n1, r_n2, n_n2;
    logic [8:0] r_root, n_root, r_walk, n_walk;
    logic r_ready, n_ready;
    t_qent r_cur, n_cur;
    logic [7:0] r_sh, n_sh;
    logic [3:0] r_bit, n_bit;
    logic r_pend_vld, n_pend_vld;
    logic [7:0] r_pend_sym, n_pend_sym;
    logic r_o_vld, n_o_vld, r_o_last, n_o_last;
    logic [7:0] r_o_sym, n_o_sym;

    logic [30:0] r_sw_q;
    logic        r_sw_v;
    logic [41:0] r_fr_q;
    logic [17:0] r_ch_q;

    logic sw_we, sw_re, fr_we, fr_re, ch_we, ch_re;
    logic [AW-1:0] fr_waddr, ch_raddr;
    logic [41:0] fr_wdata;
    logic [17:0] ch_wdata;

    logic out_free;
    logic [32:0] sum;
    logic [8:0] nxt, walk_new;
    logic leaf;

    assign out_free    = !r_o_vld || !i_out_stall;
    assign o_out_valid = r_o_vld;
    assign o_symbol    = r_o_sym;
    assign o_run_last  = r_o_last;

    always_comb begin
        n_state = r_state;     n_sw_vld = r_sw_vld;
        n_cnt = r_cnt;         n_rd_idx = r_rd_idx;  n_k = r_k;
        n_rd_vld = r_rd_vld;   n_iss_done = r_iss_done;
        n_f1 = r_f1; n_f2 = r_f2; n_m1 = r_m1; n_m2 = r_m2;
        n_i1 = r_i1; n_i2 = r_i2; n_n1 = r_n1; n_n2 = r_n2;
        n_root = r_root; n_walk = r_walk; n_ready = r_ready;
        n_cur = r_cur; n_sh = r_sh; n_bit = r_bit;
        n_pend_vld = r_pend_vld; n_pend_sym = r_pend_sym;
        n_o_vld = r_o_vld && i_out_stall;
        n_o_sym = r_o_sym; n_o_last = r_o_last;
        o_q_pop = 1'b0;
        sw_we = 1'b0; sw_re = 1'b0; fr_we = 1'b0; fr_re = 1'b0;
        ch_we = 1'b0; ch_re = 1'b0;
        fr_waddr = r_rd_idx; fr_wdata = '0;
        ch_raddr = r_walk[AW-1:0]; ch_wdata = {r_n2, r_n1};
        sum = {1'b0, r_m1} + {1'b0, r_m2};
        nxt = r_sh[7] ? r_ch_q[17:9] : r_ch_q[8:0];
        leaf = !nxt[8];
        walk_new = leaf ? r_root : nxt;

        case (r_state)
            B_IDLE: begin
                if (i_q_vld) begin
                    o_q_pop = 1'b1;
                    case (i_q.kind)
                        K_LOAD: begin
                            sw_we = 1'b1;
                            n_sw_vld[i_q.idx[AW-1:0]] = 1'b1;
                        end
                        K_BUILD: begin
                            n_state = B_INIT;
                            n_cnt = '0; n_iss_done = 1'b0; n_rd_vld = 1'b0; n_k = '0;
                        end
                        K_DEC: begin
                            if (r_ready) begin
                                n_cur = i_q;
                                n_sh  = i_q.data;
                                n_bit = 4'd0;
                                n_state = (i_q.nbits == 4'd0) ? B_DEND : B_DFETCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            B_INIT, B_SCAN: begin
                // issue one read a cycle, consume the registered word in the next cycle
                if (!r_iss_done) begin
                    sw_re = (r_state == B_INIT);
                    fr_re = (r_state == B_SCAN);
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_cnt;
                    if (r_cnt == LAST_IDX) begin
                        n_iss_done = 1'b1;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end else begin
                    n_rd_vld = 1'b0;
                end
                if (r_rd_vld) begin
                    if (r_state == B_INIT) begin
                        fr_we = 1'b1;
                        fr_wdata = {1'b1, 9'(r_rd_idx), (r_sw_v ? {1'b0, r_sw_q} : 32'd0)};
                    end else if (r_fr_q[41]) begin
                        // strict compares in index order keep the lowest index on ties
                        if (!r_f1 || r_fr_q[31:0] < r_m1) begin
                            n_m2 = r_m1; n_i2 = r_i1; n_n2 = r_n1; n_f2 = r_f1;
                            n_m1 = r_fr_q[31:0]; n_i1 = r_rd_idx;
                            n_n1 = r_fr_q[40:32]; n_f1 = 1'b1;
                        end else if (!r_f2 || r_fr_q[31:0] < r_m2) begin
                            n_m2 = r_fr_q[31:0]; n_i2 = r_rd_idx;
                            n_n2 = r_fr_q[40:32]; n_f2 = 1'b1;
                        end
                    end
                    if (r_rd_idx == LAST_IDX) begin
                        n_state = (r_state == B_INIT) ? B_SCAN : B_MERGE0;
                        n_cnt = '0; n_iss_done = 1'b0; n_rd_vld = 1'b0;
                        if (r_state == B_INIT) begin
                            n_f1 = 1'b0; n_f2 = 1'b0;
                        end
                    end
                end
            end
            B_MERGE0: begin
                fr_we = 1'b1;
                fr_waddr = r_i1;
                fr_wdata = {1'b1, NODE_BASE + 9'(r_k), (sum[32] ? 32'hFFFF_FFFF : sum[31:0])};
                ch_we = 1'b1;
                n_state = B_MERGE1;
            end
            B_MERGE1: begin
                fr_we = 1'b1;
                fr_waddr = r_i2;
                fr_wdata = '0;
                if (r_k == LAST_NODE) begin
                    n_root = NODE_BASE + 9'(r_k);
                    n_walk = NODE_BASE + 9'(r_k);
                    n_ready = 1'b1;
                    n_state = B_IDLE;
                end else begin
                    n_k = r_k + 1'b1;
                    n_state = B_SCAN;
                    n_cnt = '0; n_iss_done = 1'b0; n_rd_vld = 1'b0;
                    n_f1 = 1'b0; n_f2 = 1'b0;
                end
            end
            B_DFETCH: begin
                ch_re = 1'b1;
                n_state = B_DBIT;
            end
            B_DBIT: begin
                // hold while a second symbol would overrun a busy output
                if (!(leaf && r_pend_vld && !out_free)) begin
                    if (leaf) begin
                        if (r_pend_vld) begin
                            n_o_vld = 1'b1; n_o_sym = r_pend_sym; n_o_last = 1'b0;
                        end
                        n_pend_vld = 1'b1;
                        n_pend_sym = nxt[7:0];
                    end
                    n_walk = walk_new;
                    n_sh = {r_sh[6:0], 1'b0};
                    if (r_bit == r_cur.nbits - 4'd1) begin
                        n_state = B_DEND;
                    end else begin
                        ch_re = 1'b1;
                        ch_raddr = walk_new[AW-1:0];
                        n_bit = r_bit + 4'd1;
                    end
                end
            end
            B_DEND: begin
                if (!r_pend_vld || out_free) begin
                    if (r_pend_vld) begin
                        n_o_vld = 1'b1; n_o_sym = r_pend_sym; n_o_last = 1'b1;
                        n_pend_vld = 1'b0;
                    end
                    if (r_cur.last_byte) begin
                        n_walk = r_root;
                    end
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;  r_sw_vld <= '0;
            r_cnt <= '0; r_k <= '0; r_rd_vld <= 1'b0; r_iss_done <= 1'b0;
            r_f1 <= 1'b0; r_f2 <= 1'b0;
            r_root <= '0; r_walk <= '0; r_ready <= 1'b0;
            r_pend_vld <= 1'b0; r_o_vld <= 1'b0; r_bit <= '0;
        end else begin
            r_state <= n_state; r_sw_vld <= n_sw_vld;
            r_cnt <= n_cnt; r_k <= n_k; r_rd_vld <= n_rd_vld; r_iss_done <= n_iss_done;
            r_f1 <= n_f1; r_f2 <= n_f2;
            r_root <= n_root; r_walk <= n_walk; r_ready <= n_ready;
            r_pend_vld <= n_pend_vld; r_o_vld <= n_o_vld; r_bit <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
        r_m1 <= n_m1; r_m2 <= n_m2; r_i1 <= n_i1; r_i2 <= n_i2;
        r_n1 <= n_n1; r_n2 <= n_n2;
        r_cur <= n_cur; r_sh <= n_sh; r_pend_sym <= n_pend_sym;
        r_o_sym <= n_o_sym; r_o_last <= n_o_last;
    end

    always_ff @(posedge i_clk) begin
        if (sw_we) begin
            sw_mem[i_q.idx[AW-1:0]] <= i_q.value;
        end
        if (sw_re) begin
            r_sw_q <= sw_mem[r_cnt];
            r_sw_v <= r_sw_vld[r_cnt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fr_we) begin
            fr_mem[fr_waddr] <= fr_wdata;
        end
        if (fr_re) begin
            r_fr_q <= fr_mem[r_cnt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ch_we) begin
            ch_mem[r_k] <= ch_wdata;
        end
        if (ch_re) begin
            r_ch_q <= ch_mem[ch_raddr];
        end
    end

    a_pend_in_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> (r_state == B_DBIT || r_state == B_DEND))
        else $error("pending symbol outside decode");

    a_walk_internal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> r_walk[8])
        else $error("walk node is a leaf after build");

    a_merge_two_picks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_MERGE0) |-> (r_f1 && r_f2 && r_i1 != r_i2))
        else $error("merge without two distinct picks");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != B_DBIT && r_state != B_DEND) |=> !$rose(r_o_vld))
        else $error("output raised outside decode");

endmodule
